// ===== sv/assert_macros.svh =====
// Assertion macros used by the MD5 controller (md5_ctrl).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== sv/md5_pkg.sv =====
// Shared types, constants and round functions of the MD5 engine.
// No dependencies.
package md5_pkg;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_PAD, ST_OUT0, ST_OUT1
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic       take_byte;  // write byte lane, advance length
        logic       pad_mark;   // write 0x80, clear rest of block
        logic       clear_all;  // zero whole block
        logic       put_len;    // write length words
        logic       round_load; // copy chaining words into working words
        logic       round_step; // run one round
        logic       round_fold; // add working words into chaining words
        logic       reinit;     // back to initial state
        logic [5:0] round_idx;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic       block_full; // byte position is 63
        logic       pad_two;    // position >= 56
    } t_stat;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] round_rot(input logic [5:0] i);
        logic [4:0] r [16];
        r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return r[{i[5:4], i[1:0]}];
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction
endpackage

// ===== sv/md5_datapath.sv =====
// Datapath of the MD5 engine: block buffer, length, chaining and round words.
// Depends on md5_pkg.
module md5_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_message_byte,
    input  md5_pkg::t_cmd   i_cmd,
    output md5_pkg::t_stat  o_stat,
    output logic [127:0]    o_digest
);
    import md5_pkg::*;

    logic [31:0] r_buf [16];
    logic [63:0] r_len;
    logic [31:0] r_ch [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  pos;
    logic [31:0] f, t, rot;
    logic [4:0]  s;

    assign pos = r_len[8:3];
    assign o_stat.block_full = (pos == 6'd63);
    assign o_stat.pad_two = pos[5] & pos[4] & pos[3];
    assign o_digest = {r_ch[3], r_ch[2], r_ch[1], r_ch[0]};

    always_comb begin
        case (i_cmd.round_idx[5:4])
            2'd0: f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        s = round_rot(i_cmd.round_idx);
        t = r_a + f + r_buf[msg_index(i_cmd.round_idx)] + round_k(i_cmd.round_idx);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_buf[pos[5:2]][pos[1:0]*8 +: 8] <= i_message_byte;
        end
        if (i_cmd.pad_mark) begin
            for (int b = 0; b < 64; b++) begin
                // leave the length words to put_len
                if (!(i_cmd.put_len && b >= 56)) begin
                    if (6'(b) == pos) r_buf[b/4][(b%4)*8 +: 8] <= 8'h80;
                    else if (6'(b) > pos) r_buf[b/4][(b%4)*8 +: 8] <= 8'h00;
                end
            end
        end
        if (i_cmd.clear_all) begin
            for (int w = 0; w < 16; w++) begin
                if (!(i_cmd.put_len && w >= 14)) r_buf[w] <= '0;
            end
        end
        if (i_cmd.put_len) begin
            r_buf[14] <= r_len[31:0];
            r_buf[15] <= r_len[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_len <= '0;
            r_ch[0] <= INIT_A;
            r_ch[1] <= INIT_B;
            r_ch[2] <= INIT_C;
            r_ch[3] <= INIT_D;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
        end else begin
            if (i_cmd.take_byte) r_len <= r_len + 64'd8;
            if (i_cmd.round_load && i_cmd.round_fold) begin
                // second block starts from the freshly folded chaining words
                r_a <= r_ch[0] + r_a; r_b <= r_ch[1] + r_b;
                r_c <= r_ch[2] + r_c; r_d <= r_ch[3] + r_d;
            end else if (i_cmd.round_load) begin
                r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
            end else if (i_cmd.round_step) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + rot;
            end
            if (i_cmd.round_fold) begin
                r_ch[0] <= r_ch[0] + r_a;
                r_ch[1] <= r_ch[1] + r_b;
                r_ch[2] <= r_ch[2] + r_c;
                r_ch[3] <= r_ch[3] + r_d;
            end
        end
    end
endmodule

// ===== sv/md5_ctrl.sv =====
// Controller of the MD5 engine: sequences byte intake, rounds, padding, output.
// Depends on md5_pkg and assert_macros.svh.
`include "assert_macros.svh"
module md5_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_byte_present,
    input  logic            i_end_of_message,
    input  md5_pkg::t_stat  i_stat,
    output md5_pkg::t_cmd   o_cmd,
    output logic            busy,
    output logic            o_out_valid,
    output logic            o_out_half
);
    import md5_pkg::*;

    t_state     r_state, n_state;
    logic [6:0] r_rnd, n_rnd;   // 64 = fold cycle
    logic       r_fin, n_fin;   // message end pending
    logic       r_last, n_last; // current block is the length block

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_fin   <= n_fin;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd = r_rnd;
        n_fin = r_fin;
        n_last = r_last;
        o_cmd = '0;
        o_cmd.round_idx = r_rnd[5:0];
        busy = (r_state != ST_IDLE);
        o_out_valid = 1'b0;
        o_out_half = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_fin = i_end_of_message;
                    n_last = 1'b0;
                    n_rnd = '0;
                    if (i_byte_present) begin
                        o_cmd.take_byte = 1'b1;
                        if (i_stat.block_full) begin
                            o_cmd.round_load = 1'b1;
                            n_state = ST_ROUND;
                        end else if (i_end_of_message) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // append mark; length goes in now unless a second block is needed
                o_cmd.pad_mark = 1'b1;
                o_cmd.round_load = 1'b1;
                n_rnd = '0;
                if (!i_stat.pad_two) begin
                    o_cmd.put_len = 1'b1;
                    n_last = 1'b1;
                end
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_rnd[6]) begin
                    o_cmd.round_fold = 1'b1;
                    n_rnd = '0;
                    if (r_last) begin
                        n_state = ST_OUT0;
                    end else if (r_fin) begin
                        // full block done, padding still owed
                        if (i_stat.pad_two) begin
                            o_cmd.clear_all = 1'b1;
                            o_cmd.put_len = 1'b1;
                            n_last = 1'b1;
                            n_state = ST_ROUND;
                        end else begin
                            n_state = ST_PAD;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.round_step = 1'b1;
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_OUT0: begin
                o_out_valid = 1'b1;
                n_state = ST_OUT1;
            end
            ST_OUT1: begin
                o_out_valid = 1'b1;
                o_out_half = 1'b1;
                o_cmd.reinit = 1'b1;
                n_fin = 1'b0;
                n_last = 1'b0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // second block after a fold needs the working words reloaded
        if (r_state == ST_ROUND && r_rnd[6] && !r_last && r_fin && i_stat.pad_two)
            o_cmd.round_load = 1'b1;
    end

    `CHK_IMPL(a_out_seq, i_clk, i_rst_n, r_state == ST_OUT0, n_state == ST_OUT1)
    `CHK_NEXT(a_rnd_bound, i_clk, i_rst_n, r_state == ST_ROUND && !r_rnd[6], r_rnd != 7'd0)
    `CHK_IMPL(a_idle_rnd, i_clk, i_rst_n, r_state == ST_IDLE, r_rnd == 7'd0 || r_rnd == 7'd64)
endmodule

// ===== sv/md5_hash_engine.sv =====
// Top level of the MD5 engine: controller plus datapath.
// Depends on md5_pkg, md5_ctrl and md5_datapath.
//
// One byte is taken per start pulse while busy is low. A byte that fills the
// 64-byte block holds busy high through 64 rounds in one shared round unit,
// then the fold into the chaining words. An end mark takes a padding step, then
// 64 rounds and a fold per compressed block (one or two blocks), then the digest
// appears as two words under o_valid, low half first; the receiver cannot stall.
module md5_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    output logic [63:0] o_digest_half,
    output logic        o_half_index,
    output logic        o_last_result
);
    import md5_pkg::*;

    t_cmd         cmd;
    t_stat        stat;
    logic [127:0] digest;
    logic         half;

    md5_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_byte_present, .i_end_of_message,
        .i_stat(stat), .o_cmd(cmd), .busy, .o_out_valid(o_valid), .o_out_half(half)
    );

    md5_datapath u_dp (
        .i_clk, .i_rst_n, .i_message_byte, .i_cmd(cmd), .o_stat(stat), .o_digest(digest)
    );

    assign o_digest_half = half ? digest[127:64] : digest[63:0];
    assign o_half_index  = half;
    assign o_last_result = half;
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for md5_hash_engine: byte words go in under start/busy,
// digest halves come back under o_valid and are checked against an MD5 model.
// Depends on the RTL files (md5_pkg, md5_hash_engine and its submodules).
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_message_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic [63:0] o_digest_half;
    logic        o_half_index;
    logic        o_last_result;

    md5_hash_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_message_byte(i_message_byte), .i_byte_present(i_byte_present),
        .i_end_of_message(i_end_of_message), .o_valid(o_valid),
        .o_digest_half(o_digest_half), .o_half_index(o_half_index),
        .o_last_result(o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [63:0] half;
        logic        idx;
        logic        last;
    } t_digest_word;

    t_digest_word digest_q[$];
    int errors = 0;
    int words_in = 0;
    int digests_seen = 0;

    // predictor state
    logic [31:0] chain[4];
    logic [31:0] blk[16];
    logic [63:0] msg_bits;

    localparam logic [31:0] K_TAB[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    localparam int ROT_TAB[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

    function automatic void init_chain();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        msg_bits = '0;
    endfunction

    function automatic void set_byte(int pos, logic [7:0] v);
        blk[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int g, s;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = d ^ (b & (c ^ d)); g = i;
            end else if (i < 32) begin
                f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            s = ROT_TAB[(i / 16) * 4 + i % 4];
            t = a + f + blk[g] + K_TAB[i];
            t = (t << s) | (t >> (32 - s));
            a = d; d = c; c = b; b = b + t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    // advance the digest model by one word; push the two halves on the end mark
    function automatic void predict_digest(logic [7:0] bv, logic pres, logic eom);
        int pos;
        t_digest_word w;
        if (pres) begin
            pos = int'(msg_bits[8:3]);
            set_byte(pos, bv);
            msg_bits += 64'd8;
            if (pos == 63) compress_block();
        end
        if (!eom) return;
        pos = int'(msg_bits[8:3]);
        set_byte(pos, 8'h80);
        for (int p = pos + 1; p < 64; p++) set_byte(p, 8'h00);
        if (pos >= 56) begin
            compress_block();
            for (int p = 0; p < 64; p++) set_byte(p, 8'h00);
        end
        blk[14] = msg_bits[31:0];
        blk[15] = msg_bits[63:32];
        compress_block();
        w.half = {chain[1], chain[0]}; w.idx = 1'b0; w.last = 1'b0;
        digest_q.push_back(w);
        w.half = {chain[3], chain[2]}; w.idx = 1'b1; w.last = 1'b1;
        digest_q.push_back(w);
        init_chain();
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && o_valid) begin
            if (digest_q.size() == 0) begin
                report_mismatch("digest word with none expected");
            end else begin
                exp_w = digest_q.pop_front();
                digests_seen++;
                if (o_digest_half !== exp_w.half)
                    report_mismatch($sformatf("half %h, want %h", o_digest_half, exp_w.half));
                if (o_half_index !== exp_w.idx)
                    report_mismatch($sformatf("half_index %b, want %b",
                                              o_half_index, exp_w.idx));
                if (o_last_result !== exp_w.last)
                    report_mismatch($sformatf("last_result %b, want %b",
                                              o_last_result, exp_w.last));
            end
        end
    end

    bit idle_ok = 1'b1;

    // present one word and hold it until accepted; start stays up for the caller
    task automatic send_word(logic [7:0] bv, logic pres, logic eom);
        while (idle_ok && $urandom_range(99) < 24) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_message_byte <= bv;
        i_byte_present <= pres;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_digest(bv, pres, eom);
        words_in++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, logic empty_end);
        for (int n = 0; n < len; n++)
            send_word(8'($urandom), 1'b1, (n == len - 1) && !empty_end);
        if (empty_end || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    typedef struct {
        logic [7:0]   bv;
        logic         pres;
        logic         eom;
        logic         has_exp;
        logic [127:0] exp_digest;
    } t_dir_row;

    // empty string, "a", then ignored words, bytes 00/ff, and "abc" with the
    // end mark riding on the last byte
    t_dir_row dir_rows[] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e},
        '{8'h61, 1'b1, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661},
        '{8'hff, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{8'hff, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72}
    };

    initial begin
        int len;
        logic [127:0] dig;
        init_chain();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].bv, dir_rows[r].pres, dir_rows[r].eom);
            if (dir_rows[r].has_exp) begin
                dig = {digest_q[1].half, digest_q[0].half};
                // digest bytes reversed into printed order for the known vectors
                if ({<<8{dig}} !== dir_rows[r].exp_digest)
                    report_mismatch("known digest vector");
            end
        end

        // long run without idling: full blocks and the two-block padding edge
        idle_ok = 1'b0;
        send_message(64, 1'b0);
        send_message(56, 1'b0);
        send_message(55, 1'b1);
        idle_ok = 1'b1;

        // hold off until the last digest has drained
        start <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);

        for (int m = 0; m < 15; m++) begin
            case ($urandom_range(3))
                0: len = $urandom_range(3);
                1: len = $urandom_range(8) + 52;
                default: len = $urandom_range(20);
            endcase
            send_message(len, $urandom_range(3) == 0);
            if ($urandom_range(5) == 0) send_word(8'($urandom), 1'b0, 1'b0);
        end
        for (int n = 0; n < 20; n++)
            send_word(8'($urandom), 1'($urandom_range(1)), $urandom_range(7) == 0);
        send_word(8'h00, 1'b0, 1'b1);
        start <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("sent %0d words, checked %0d digest halves, incl. empty, one-byte,",
                 words_in, digests_seen);
        $display("block-boundary and two-block padding messages plus stray words");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
